// ----- hw/rtl/tlmt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlmt_pkg: shared types and constants for the thread latency mean table
// Request/result layouts, table row, controller state, command/status groups.
// ----------------------------------------------------------------------------
package tlmt_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int OP_W     = 2;
    localparam int THREAD_W = 22;
    localparam int LAT_W    = 16;
    localparam int CPU_W    = 10;
    localparam int MEAN_W   = 24;
    localparam int CNT_W    = 32;
    localparam int STATUS_W = 3;

    localparam int PROD_W    = MEAN_W + CNT_W;
    localparam int NUM_W     = PROD_W + 1;
    localparam int DEN_W     = CNT_W + 1;
    localparam int DIV_STEPS = MEAN_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
    localparam int FRAC_W    = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [OP_W-1:0] OP_ACCESS      = 2'd0;
    localparam logic [OP_W-1:0] OP_RESET_STATS = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_UPDATED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_RESET    = 3'd3,
        ST_CLEARED  = 3'd4
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [THREAD_W-1:0] thread_id;
        logic [LAT_W-1:0]    latency;
        logic [CPU_W-1:0]    cpu_id;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [MEAN_W-1:0]   mean_total;
        logic [CNT_W-1:0]    count_total;
        logic [MEAN_W-1:0]   mean_since_reset;
        logic [CNT_W-1:0]    count_since_reset;
        logic [CPU_W-1:0]    last_cpu;
    } t_res;

    typedef struct packed {
        logic [THREAD_W-1:0] thread;
        logic [CPU_W-1:0]    cpu;
        logic [MEAN_W-1:0]   mean_t;
        logic [CNT_W-1:0]    cnt_t;
        logic [MEAN_W-1:0]   mean_r;
        logic [CNT_W-1:0]    cnt_r;
    } t_row;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_MUL,
        S_DINIT,
        S_DIV,
        S_STORE,
        S_WRITE,
        S_INSERT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic    load;
        logic    rst_recent;
        logic    clr_table;
        logic    scan_start;
        logic    scan;
        logic    mul;
        logic    div_init;
        logic    div_step;
        logic    store;
        logic    sel_recent;
        logic    write_upd;
        logic    insert;
        logic    emit;
        logic    zero;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            scan_done;
        logic            hit;
        logic            free;
        logic            div_done;
        logic            out_busy;
    } t_stat;

    function automatic logic [CNT_W-1:0] f_sat_inc(input logic [CNT_W-1:0] n);
        f_sat_inc = (n == CNT_MAX) ? n : n + CNT_W'(1);
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tlmt_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlmt_ctrl: sequencer for the thread latency mean table
// Access: scan, two mean divisions and write-back or insert; then result.
// ----------------------------------------------------------------------------
module tlmt_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_stall,
    input  wire tlmt_pkg::t_stat i_stat,
    output tlmt_pkg::t_cmd       o_cmd
);

    tlmt_pkg::t_state  r_state, n_state;
    logic              r_pass, n_pass;
    tlmt_pkg::t_status r_status, n_status;
    logic              r_zero, n_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tlmt_pkg::S_IDLE;
            r_pass   <= 1'b0;
            r_status <= tlmt_pkg::ST_UPDATED;
            r_zero   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pass   <= n_pass;
            r_status <= n_status;
            r_zero   <= n_zero;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pass      = r_pass;
        n_status    = r_status;
        n_zero      = r_zero;
        o_req_stall = 1'b1;
        o_cmd       = '0;
        o_cmd.status     = r_status;
        o_cmd.zero       = r_zero;
        o_cmd.sel_recent = r_pass;
        unique case (r_state)
            tlmt_pkg::S_IDLE: begin
                o_req_stall = 1'b0;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = tlmt_pkg::S_DISPATCH;
                end
            end
            tlmt_pkg::S_DISPATCH: begin
                if (i_stat.op == tlmt_pkg::OP_ACCESS) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = tlmt_pkg::S_SCAN;
                end else if (i_stat.op == tlmt_pkg::OP_RESET_STATS) begin
                    o_cmd.rst_recent = 1'b1;
                    n_status         = tlmt_pkg::ST_RESET;
                    n_zero           = 1'b1;
                    n_state          = tlmt_pkg::S_FINISH;
                end else begin
                    o_cmd.clr_table = 1'b1;
                    n_status        = tlmt_pkg::ST_CLEARED;
                    n_zero          = 1'b1;
                    n_state         = tlmt_pkg::S_FINISH;
                end
            end
            tlmt_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    if (i_stat.hit) begin
                        n_pass  = 1'b0;
                        n_state = tlmt_pkg::S_MUL;
                    end else if (i_stat.free) begin
                        n_state = tlmt_pkg::S_INSERT;
                    end else begin
                        n_status = tlmt_pkg::ST_FULL;
                        n_zero   = 1'b1;
                        n_state  = tlmt_pkg::S_FINISH;
                    end
                end
            end
            tlmt_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = tlmt_pkg::S_DINIT;
            end
            tlmt_pkg::S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = tlmt_pkg::S_DIV;
            end
            tlmt_pkg::S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = tlmt_pkg::S_STORE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            tlmt_pkg::S_STORE: begin
                o_cmd.store = 1'b1;
                if (!r_pass) begin
                    n_pass  = 1'b1;
                    n_state = tlmt_pkg::S_MUL;
                end else begin
                    n_state = tlmt_pkg::S_WRITE;
                end
            end
            tlmt_pkg::S_WRITE: begin
                o_cmd.write_upd = 1'b1;
                n_status        = tlmt_pkg::ST_UPDATED;
                n_zero          = 1'b0;
                n_state         = tlmt_pkg::S_FINISH;
            end
            tlmt_pkg::S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_status     = tlmt_pkg::ST_INSERTED;
                n_zero       = 1'b0;
                n_state      = tlmt_pkg::S_FINISH;
            end
            tlmt_pkg::S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = tlmt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tlmt_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/tlmt_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlmt_dp: datapath of the thread latency mean table
// Row memory, valid/stale flags, scan compare, multiply, restoring divider,
// result register.
// ----------------------------------------------------------------------------
module tlmt_dp #(
    parameter int TABLE_ENTRIES = tlmt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tlmt_pkg::t_req  i_req,
    input  wire tlmt_pkg::t_cmd  i_cmd,
    output tlmt_pkg::t_stat      o_stat,
    output logic                 o_res_valid,
    input  wire logic            i_res_stall,
    output tlmt_pkg::t_res       o_res
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    tlmt_pkg::t_row r_mem [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [TABLE_ENTRIES-1:0] r_stale;

    tlmt_pkg::t_req r_req;
    tlmt_pkg::t_row r_row;
    tlmt_pkg::t_row r_rd_row;
    tlmt_pkg::t_row n_row;
    tlmt_pkg::t_row ins_row;
    tlmt_pkg::t_row upd_row;
    tlmt_pkg::t_row hit_row;

    logic [CW-1:0] r_issue_cnt;
    logic [IW-1:0] r_cmp_idx;
    logic          r_cmp_v;
    logic          r_scan_done;
    logic          r_hit_f;
    logic          r_free_f;
    logic [IW-1:0] r_hit_idx;
    logic [IW-1:0] r_free_idx;
    logic          issue;
    logic          mem_we;
    logic [IW-1:0] wr_idx;

    logic [tlmt_pkg::MEAN_W-1:0]   mul_mean;
    logic [tlmt_pkg::CNT_W-1:0]    mul_cnt;
    logic [tlmt_pkg::PROD_W-1:0]   r_prod;
    logic [tlmt_pkg::DEN_W-1:0]    r_den;
    logic [tlmt_pkg::NUM_W-1:0]    num;
    logic [tlmt_pkg::DEN_W-1:0]    r_rem;
    logic [tlmt_pkg::MEAN_W-1:0]   r_q;
    logic [tlmt_pkg::DCNT_W-1:0]   r_div_cnt;
    logic [tlmt_pkg::DEN_W:0]      trial;
    logic [tlmt_pkg::DEN_W:0]      diff;
    logic [tlmt_pkg::MEAN_W-1:0]   lat_q;

    logic           r_out_valid;
    tlmt_pkg::t_res r_out;

    assign issue  = i_cmd.scan && (r_issue_cnt < CW'(TABLE_ENTRIES));
    assign mem_we = i_cmd.insert || i_cmd.write_upd;
    assign wr_idx = i_cmd.insert ? r_free_idx : r_hit_idx;
    assign lat_q  = {r_req.latency, {tlmt_pkg::FRAC_W{1'b0}}};

    always_comb begin
        hit_row = r_rd_row;
        if (r_stale[r_cmp_idx]) begin
            hit_row.mean_r = '0;
            hit_row.cnt_r  = '0;
        end
    end

    always_comb begin
        ins_row.thread = r_req.thread_id;
        ins_row.cpu    = r_req.cpu_id;
        ins_row.mean_t = lat_q;
        ins_row.cnt_t  = tlmt_pkg::CNT_W'(1);
        ins_row.mean_r = lat_q;
        ins_row.cnt_r  = tlmt_pkg::CNT_W'(1);
        upd_row        = r_row;
        upd_row.cpu    = r_req.cpu_id;
        upd_row.cnt_t  = tlmt_pkg::f_sat_inc(r_row.cnt_t);
        upd_row.cnt_r  = tlmt_pkg::f_sat_inc(r_row.cnt_r);
        n_row          = i_cmd.insert ? ins_row : upd_row;
    end

    always_comb begin
        mul_mean = i_cmd.sel_recent ? r_row.mean_r : r_row.mean_t;
        mul_cnt  = i_cmd.sel_recent ? r_row.cnt_r : r_row.cnt_t;
        num      = {1'b0, r_prod} + tlmt_pkg::NUM_W'(lat_q);
        trial    = {r_rem, r_q[tlmt_pkg::MEAN_W-1]};
        diff     = trial - {1'b0, r_den};
    end

    // row memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_idx] <= n_row;
        end
        r_rd_row <= r_mem[r_issue_cnt[IW-1:0]];
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_stale     <= '0;
            r_issue_cnt <= '0;
            r_cmp_v     <= 1'b0;
            r_scan_done <= 1'b0;
            r_hit_f     <= 1'b0;
            r_free_f    <= 1'b0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_table) begin
                r_valid <= '0;
            end
            if (i_cmd.rst_recent) begin
                r_stale <= '1;
            end
            if (mem_we) begin
                r_valid[wr_idx] <= 1'b1;
                r_stale[wr_idx] <= 1'b0;
            end
            if (i_cmd.scan_start) begin
                r_issue_cnt <= '0;
                r_cmp_v     <= 1'b0;
                r_scan_done <= 1'b0;
                r_hit_f     <= 1'b0;
                r_free_f    <= 1'b0;
            end else begin
                if (issue) begin
                    r_issue_cnt <= r_issue_cnt + CW'(1);
                end
                r_cmp_v <= issue;
                if (r_cmp_v) begin
                    if (r_valid[r_cmp_idx]) begin
                        if (!r_hit_f && r_rd_row.thread == r_req.thread_id) begin
                            r_hit_f <= 1'b1;
                        end
                    end else if (!r_free_f) begin
                        r_free_f <= 1'b1;
                    end
                    if (r_cmp_idx == IW'(TABLE_ENTRIES - 1)) begin
                        r_scan_done <= 1'b1;
                    end
                end
            end
            if (i_cmd.div_init) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + tlmt_pkg::DCNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (issue) begin
            r_cmp_idx <= r_issue_cnt[IW-1:0];
        end
        if (r_cmp_v && !i_cmd.scan_start) begin
            if (r_valid[r_cmp_idx]) begin
                if (!r_hit_f && r_rd_row.thread == r_req.thread_id) begin
                    r_hit_idx <= r_cmp_idx;
                    r_row     <= hit_row;
                end
            end else if (!r_free_f) begin
                r_free_idx <= r_cmp_idx;
            end
        end
        if (i_cmd.mul) begin
            r_prod <= tlmt_pkg::PROD_W'(mul_mean) * tlmt_pkg::PROD_W'(mul_cnt);
            r_den  <= {1'b0, mul_cnt} + tlmt_pkg::DEN_W'(1);
        end
        if (i_cmd.div_init) begin
            r_rem <= num[tlmt_pkg::NUM_W-1:tlmt_pkg::MEAN_W];
            r_q   <= num[tlmt_pkg::MEAN_W-1:0];
        end else if (i_cmd.div_step) begin
            if (!diff[tlmt_pkg::DEN_W]) begin
                r_rem <= diff[tlmt_pkg::DEN_W-1:0];
            end else begin
                r_rem <= trial[tlmt_pkg::DEN_W-1:0];
            end
            r_q <= {r_q[tlmt_pkg::MEAN_W-2:0], ~diff[tlmt_pkg::DEN_W]};
        end
        if (i_cmd.store) begin
            if (i_cmd.sel_recent) begin
                r_row.mean_r <= r_q;
            end else begin
                r_row.mean_t <= r_q;
            end
        end
        if (mem_we) begin
            r_row <= n_row;
        end
        if (i_cmd.emit) begin
            r_out.status <= i_cmd.status;
            if (i_cmd.zero) begin
                r_out.mean_total        <= '0;
                r_out.count_total       <= '0;
                r_out.mean_since_reset  <= '0;
                r_out.count_since_reset <= '0;
                r_out.last_cpu          <= '0;
            end else begin
                r_out.mean_total        <= r_row.mean_t;
                r_out.count_total       <= r_row.cnt_t;
                r_out.mean_since_reset  <= r_row.mean_r;
                r_out.count_since_reset <= r_row.cnt_r;
                r_out.last_cpu          <= r_row.cpu;
            end
        end
    end

    assign o_stat.op        = r_req.op;
    assign o_stat.scan_done = r_scan_done;
    assign o_stat.hit       = r_hit_f;
    assign o_stat.free      = r_free_f;
    assign o_stat.div_done  = (r_div_cnt == tlmt_pkg::DCNT_W'(tlmt_pkg::DIV_STEPS));
    assign o_stat.out_busy  = r_out_valid && i_res_stall;
    assign o_res_valid      = r_out_valid;
    assign o_res            = r_out;

`ifndef ASSERT_OFF
    a_scan_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_done |-> (r_issue_cnt == CW'(TABLE_ENTRIES)))
        else $error("scan finished before all entries were issued");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_den))
        else $error("divider remainder out of range");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !(r_out_valid && i_res_stall))
        else $error("result overwritten while stalled");

    a_insert_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> (r_free_f && !r_valid[r_free_idx]))
        else $error("insert into an occupied slot");

    a_update_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write_upd |-> (r_hit_f && r_valid[r_hit_idx]))
        else $error("update of an invalid entry");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/thread_latency_mean_table_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// thread_latency_mean_table_core: per-page thread latency table
// Tracks per-thread last cpu, counts and running Q16.8 latency means.
//
//   channel  dir  handshake                   payload
//   request  in   i_req_valid / o_req_stall   i_req (tlmt_pkg::t_req)
//   result   out  o_res_valid / i_res_stall   o_res (tlmt_pkg::t_res)
//
// One request at a time. An access scans every entry through the row memory
// port, and an update runs two 24-step restoring divisions on one divider.
// Reset empties the table at once; no clearing pass.
// A registered result waits under stall while the next request is accepted.
// ----------------------------------------------------------------------------
module thread_latency_mean_table_core #(
    parameter int TABLE_ENTRIES = tlmt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output logic                o_req_stall,
    input  wire tlmt_pkg::t_req i_req,
    output logic                o_res_valid,
    input  wire logic           i_res_stall,
    output tlmt_pkg::t_res      o_res
);

    tlmt_pkg::t_cmd  cmd;
    tlmt_pkg::t_stat stat;

    tlmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tlmt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire

// ----- bench/thread_latency_mean_table_checker.sv -----
// ----------------------------------------------------------------------------
// thread_latency_mean_table_checker: result checker for the latency table
// Watches the request and result channels and keeps its own copy of the
// thread table. Each accepted request yields one expected result, queued in
// order. Each accepted result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module thread_latency_mean_table_checker #(
    parameter int ENTRIES = tlmt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_stall,
    input  tlmt_pkg::t_req i_req,
    input  logic           i_res_valid,
    input  logic           i_res_stall,
    input  tlmt_pkg::t_res i_res,
    output int             o_pending,
    output int             o_fail_count
);

    logic           row_valid [ENTRIES];
    tlmt_pkg::t_row rows      [ENTRIES];
    tlmt_pkg::t_res due_results[$];
    int             mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic logic [tlmt_pkg::MEAN_W-1:0] running_mean(
        input logic [tlmt_pkg::MEAN_W-1:0] mean,
        input logic [tlmt_pkg::CNT_W-1:0]  n,
        input logic [tlmt_pkg::LAT_W-1:0]  lat);
        logic [63:0] num;
        logic [63:0] den;
        num = 64'(mean) * 64'(n) + (64'(lat) << tlmt_pkg::FRAC_W);
        den = 64'(n) + 64'd1;
        return tlmt_pkg::MEAN_W'(num / den);
    endfunction

    function automatic logic [tlmt_pkg::CNT_W-1:0] bump_count(
        input logic [tlmt_pkg::CNT_W-1:0] n);
        return (n == '1) ? n : n + 1'b1;
    endfunction

    function automatic tlmt_pkg::t_res apply_request(input tlmt_pkg::t_req req);
        tlmt_pkg::t_res res;
        int             hit;
        int             free_slot;
        int             slot;
        res = '0;
        hit = -1;
        free_slot = -1;
        slot = -1;
        if (req.op == tlmt_pkg::OP_RESET_STATS) begin
            for (int i = 0; i < ENTRIES; i++) begin
                rows[i].mean_r = '0;
                rows[i].cnt_r  = '0;
            end
            res.status = tlmt_pkg::ST_RESET;
        end else if (req.op[1]) begin
            for (int i = 0; i < ENTRIES; i++) row_valid[i] = 1'b0;
            res.status = tlmt_pkg::ST_CLEARED;
        end else begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (row_valid[i]) begin
                    if (hit < 0 && rows[i].thread == req.thread_id) hit = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (hit >= 0) begin
                slot = hit;
                rows[slot].cpu    = req.cpu_id;
                rows[slot].mean_t = running_mean(rows[slot].mean_t, rows[slot].cnt_t,
                                                 req.latency);
                rows[slot].mean_r = running_mean(rows[slot].mean_r, rows[slot].cnt_r,
                                                 req.latency);
                rows[slot].cnt_t  = bump_count(rows[slot].cnt_t);
                rows[slot].cnt_r  = bump_count(rows[slot].cnt_r);
                res.status = tlmt_pkg::ST_UPDATED;
            end else if (free_slot >= 0) begin
                slot = free_slot;
                row_valid[slot]   = 1'b1;
                rows[slot].thread = req.thread_id;
                rows[slot].cpu    = req.cpu_id;
                rows[slot].mean_t = tlmt_pkg::MEAN_W'(req.latency) << tlmt_pkg::FRAC_W;
                rows[slot].mean_r = tlmt_pkg::MEAN_W'(req.latency) << tlmt_pkg::FRAC_W;
                rows[slot].cnt_t  = tlmt_pkg::CNT_W'(1);
                rows[slot].cnt_r  = tlmt_pkg::CNT_W'(1);
                res.status = tlmt_pkg::ST_INSERTED;
            end else begin
                res.status = tlmt_pkg::ST_FULL;
            end
            if (slot >= 0) begin
                res.mean_total        = rows[slot].mean_t;
                res.count_total       = rows[slot].cnt_t;
                res.mean_since_reset  = rows[slot].mean_r;
                res.count_since_reset = rows[slot].cnt_r;
                res.last_cpu          = rows[slot].cpu;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got,
                 want);
    endtask

    always @(posedge i_clk) begin : watch
        tlmt_pkg::t_res want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                row_valid[i] = 1'b0;
                rows[i]      = '0;
            end
            due_results.delete();
            o_pending <= 0;
        end else begin
            if (i_req_valid && !i_req_stall)
                due_results.insert(due_results.size(), apply_request(i_req));
            if (i_res_valid && !i_res_stall) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result with no request due", 32'(i_res.status), '0);
                end else begin
                    want = due_results.pop_front();
                    if (i_res.status !== want.status)
                        report_mismatch("status", 32'(i_res.status), 32'(want.status));
                    if (i_res.mean_total !== want.mean_total)
                        report_mismatch("mean_total", 32'(i_res.mean_total),
                                        32'(want.mean_total));
                    if (i_res.count_total !== want.count_total)
                        report_mismatch("count_total", i_res.count_total, want.count_total);
                    if (i_res.mean_since_reset !== want.mean_since_reset)
                        report_mismatch("mean_since_reset", 32'(i_res.mean_since_reset),
                                        32'(want.mean_since_reset));
                    if (i_res.count_since_reset !== want.count_since_reset)
                        report_mismatch("count_since_reset", i_res.count_since_reset,
                                        want.count_since_reset);
                    if (i_res.last_cpu !== want.last_cpu)
                        report_mismatch("last_cpu", 32'(i_res.last_cpu), 32'(want.last_cpu));
                end
            end
            o_pending <= due_results.size();
        end
    end

endmodule

// ----- bench/thread_latency_mean_table_core_tb.sv -----
// ----------------------------------------------------------------------------
// thread_latency_mean_table_core_tb: testbench for the thread latency table
// Directed requests cover field extremes, reset and clear ops, a full table
// and a hit on a full table; random blocks then mix thread pools of varying
// size with stats resets and clears, under random request gaps and result
// stall. A side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module thread_latency_mean_table_core_tb;

    localparam logic [tlmt_pkg::OP_W-1:0] OP_CLEAR     = 2'd2;
    localparam logic [tlmt_pkg::OP_W-1:0] OP_CLEAR_ALT = 2'd3;
    localparam int RANDOM_ITEMS  = 1625;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 100;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_req_valid = 1'b0;
    tlmt_pkg::t_req i_req       = '0;
    logic           i_res_stall = 1'b0;
    logic           o_req_stall;
    logic           o_res_valid;
    tlmt_pkg::t_res o_res;

    logic no_idle     = 1'b0;
    int   stall_left  = 0;
    int   idle_cycles = 0;
    int   results_due;
    int   fail_count;

    thread_latency_mean_table_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_res       (o_res)
    );

    thread_latency_mean_table_checker stats_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req_stall  (o_req_stall),
        .i_req        (i_req),
        .i_res_valid  (o_res_valid),
        .i_res_stall  (i_res_stall),
        .i_res        (o_res),
        .o_pending    (results_due),
        .o_fail_count (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    always @(posedge i_clk) begin
        if (no_idle) begin
            i_res_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else begin
            i_res_stall <= ($urandom_range(0, 2) == 0);
            stall_left  <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_req_valid && !o_req_stall) || (o_res_valid && !i_res_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles == IDLE_LIMIT) begin
                $display("thread_latency_mean_table_core_tb: FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_request(input tlmt_pkg::t_req req);
        int gap;
        i_req_valid <= 1'b1;
        i_req       <= req;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        gap = no_idle ? 0 : pick_gap();
        if (gap != 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
    endtask

    initial begin
        tlmt_pkg::t_req                req;
        logic [tlmt_pkg::THREAD_W-1:0] pool [32];
        int                            pool_size;
        int                            block_len;
        int                            sent;
        int                            roll;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, stats reset, fill to full, hit while full, clears
        send_request(tlmt_pkg::t_req'{tlmt_pkg::OP_ACCESS, 22'h000000, 16'h0000, 10'h000});
        send_request(tlmt_pkg::t_req'{tlmt_pkg::OP_ACCESS, 22'h3FFFFF, 16'hFFFF, 10'h3FF});
        send_request(tlmt_pkg::t_req'{tlmt_pkg::OP_ACCESS, 22'h3FFFFF, 16'h0000, 10'h000});
        send_request(tlmt_pkg::t_req'{tlmt_pkg::OP_ACCESS, 22'h000000, 16'hFFFF, 10'h3FF});
        send_request(tlmt_pkg::t_req'{tlmt_pkg::OP_RESET_STATS, 22'h3FFFFF, 16'hFFFF,
                                      10'h3FF});
        send_request(tlmt_pkg::t_req'{tlmt_pkg::OP_ACCESS, 22'h000000, 16'h04D2, 10'h005});
        for (int k = 1; k <= tlmt_pkg::TABLE_ENTRIES_DEF - 1; k++)
            send_request(tlmt_pkg::t_req'{tlmt_pkg::OP_ACCESS,
                                          tlmt_pkg::THREAD_W'(k * 22'h024925),
                                          tlmt_pkg::LAT_W'($urandom()),
                                          tlmt_pkg::CPU_W'($urandom())});
        send_request(tlmt_pkg::t_req'{tlmt_pkg::OP_ACCESS, 22'h3FFFFF, 16'h8001, 10'h200});
        send_request(tlmt_pkg::t_req'{OP_CLEAR, 22'h2AAAAA, 16'h5555, 10'h155});
        send_request(tlmt_pkg::t_req'{OP_CLEAR_ALT, 22'h155555, 16'hAAAA, 10'h2AA});
        send_request(tlmt_pkg::t_req'{tlmt_pkg::OP_ACCESS, 22'h3FFFFF, 16'h0001, 10'h001});
        wait_for_results();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 4))
                0: pool_size = 2;
                1: pool_size = 5;
                2: pool_size = 12;
                3: pool_size = 17;
                default: pool_size = 28;
            endcase
            for (int k = 0; k < pool_size; k++) pool[k] = tlmt_pkg::THREAD_W'($urandom());
            no_idle   <= ($urandom_range(0, 3) == 0);
            block_len  = $urandom_range(60, 200);
            for (int n = 0; n < block_len && sent < RANDOM_ITEMS; n++) begin
                req.thread_id = pool[$urandom_range(0, pool_size - 1)];
                if ($urandom_range(0, 19) == 0)
                    req.thread_id = tlmt_pkg::THREAD_W'($urandom());
                if ($urandom_range(0, 9) == 0)
                    req.latency = $urandom_range(0, 1) ? '1 : '0;
                else
                    req.latency = tlmt_pkg::LAT_W'($urandom());
                req.cpu_id = tlmt_pkg::CPU_W'($urandom());
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    req.op = tlmt_pkg::OP_RESET_STATS;
                else if (roll < 5)
                    req.op = OP_CLEAR;
                else if (roll < 6)
                    req.op = OP_CLEAR_ALT;
                else
                    req.op = tlmt_pkg::OP_ACCESS;
                send_request(req);
                sent++;
            end
            // hold off new requests until the table has answered everything
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("thread_latency_mean_table_core_tb: PASS");
        else
            $display("thread_latency_mean_table_core_tb: FAIL");
        $finish;
    end

endmodule
